// File: src/counting_semaphore_timer_unit_core_assert.svh
// Assertion macros for the semaphore timer unit.
`ifndef COUNTING_SEMAPHORE_TIMER_UNIT_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_TIMER_UNIT_CORE_ASSERT_SVH
`ifndef SYNTH
`define CSTU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CSTU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CSTU_ASSERT_IMP(lbl, ante, cons)
`define CSTU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/cstu_pkg.sv
`default_nettype none
package cstu_pkg;

    localparam int CNT_W    = 64;
    localparam int TIME_W   = 48;
    localparam int FIRE_W   = 5;
    localparam int MAX_FIRE = 16;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_DELETE = 3'd1,
        OP_WAIT   = 3'd2,
        OP_SIGNAL = 3'd3,
        OP_TIMED  = 3'd4,
        OP_TICK   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BUSY      = 3'd2,
        ST_FULL      = 3'd3,
        ST_SATURATED = 3'd4,
        ST_BLOCKED   = 3'd5,
        ST_TMR_FULL  = 3'd6
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [3:0] result_id;
        logic       woke;
        logic [7:0] woken_task;
        logic       last;
    } t_result;

endpackage
`default_nettype wire

// File: src/cstu_sem_store.sv
`default_nettype none
module cstu_sem_store #(
    parameter int NUM_SEMS = 16,
    parameter int SW       = 4,
    parameter int DW       = 4,
    parameter int DIW      = 3,
    parameter int TB       = 8
) (
    input  wire logic                       i_clk,
    input  wire logic [SW-1:0]              i_rd_slot,
    output logic [cstu_pkg::CNT_W-1:0]      o_rd_count,
    output logic [DW-1:0]                   o_rd_depth,
    input  wire logic                       i_wr_en,
    input  wire logic [SW-1:0]              i_wr_slot,
    input  wire logic [cstu_pkg::CNT_W-1:0] i_wr_count,
    input  wire logic [DW-1:0]              i_wr_depth,
    input  wire logic [SW+DIW-1:0]          i_stk_rd_addr,
    output logic [TB-1:0]                   o_stk_rd_data,
    input  wire logic                       i_stk_wr_en,
    input  wire logic [SW+DIW-1:0]          i_stk_wr_addr,
    input  wire logic [TB-1:0]              i_stk_wr_data
);
    localparam int STK_N = NUM_SEMS << DIW;

    logic [cstu_pkg::CNT_W+DW-1:0] r_sem_mem [NUM_SEMS];
    logic [TB-1:0]                 r_stk_mem [STK_N];
    logic [cstu_pkg::CNT_W+DW-1:0] r_sem_rd;
    logic [TB-1:0]                 r_stk_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sem_mem[i_wr_slot] <= {i_wr_count, i_wr_depth};
        end
        r_sem_rd <= r_sem_mem[i_rd_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_stk_wr_en) begin
            r_stk_mem[i_stk_wr_addr] <= i_stk_wr_data;
        end
        r_stk_rd <= r_stk_mem[i_stk_rd_addr];
    end

    assign o_rd_count    = r_sem_rd[cstu_pkg::CNT_W+DW-1:DW];
    assign o_rd_depth    = r_sem_rd[DW-1:0];
    assign o_stk_rd_data = r_stk_rd;
endmodule
`default_nettype wire

// File: src/cstu_tmr_store.sv
`default_nettype none
module cstu_tmr_store #(
    parameter int NUM_TIMERS = 16,
    parameter int TW         = 4
) (
    input  wire logic                        i_clk,
    input  wire logic [TW-1:0]               i_rd_addr,
    output logic [cstu_pkg::TIME_W-1:0]      o_rd_expiry,
    input  wire logic                        i_wr_en,
    input  wire logic [TW-1:0]               i_wr_addr,
    input  wire logic [cstu_pkg::TIME_W-1:0] i_wr_expiry
);
    logic [cstu_pkg::TIME_W-1:0] r_mem [NUM_TIMERS];
    logic [cstu_pkg::TIME_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_expiry;
        end
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_expiry = r_rd;
endmodule
`default_nettype wire

// File: src/counting_semaphore_timer_unit_core.sv
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_op i_sem_id i_task_id i_init_count i_delay_us
// output  | o_valid | i_stall | o_status o_result_id o_woke o_woken_task o_last
//
// One transaction at a time. Delete, wait and signal read the slot, execute and, if a waiter is
// popped, read its task; an absent slot is answered at once as not found. Create and signal after
// delay search for a free semaphore or timer slot. A tick scans the timer memory entry by entry,
// reading then checking each, then handles each fired timer: fire, read and write back, pop, rescan, emit.
// Reset is synchronous; semaphore and timer memories need no clearing pass.
// An output stall holds the sequencer in its emit state.
`default_nettype none
`include "counting_semaphore_timer_unit_core_assert.svh"
module counting_semaphore_timer_unit_core #(
    parameter int NUM_SEMS   = 16,
    parameter int WAIT_DEPTH = 8,
    parameter int NUM_TIMERS = 16,
    parameter int TASK_BITS  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_op,
    input  wire logic [3:0]  i_sem_id,
    input  wire logic [7:0]  i_task_id,
    input  wire logic [63:0] i_init_count,
    input  wire logic [31:0] i_delay_us,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [3:0]       o_result_id,
    output logic             o_woke,
    output logic [7:0]       o_woken_task,
    output logic             o_last
);
    localparam int SW  = $clog2(NUM_SEMS);
    localparam int XW  = (SW > 4 ? SW : 4) + 1;
    localparam int DW  = $clog2(WAIT_DEPTH + 1);
    localparam int DIW = WAIT_DEPTH > 1 ? $clog2(WAIT_DEPTH) : 1;
    localparam int TW  = NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1;
    localparam int TB  = TASK_BITS < 8 ? TASK_BITS : 8;
    localparam int CW  = cstu_pkg::CNT_W;
    localparam int EW  = cstu_pkg::TIME_W;
    localparam int FW  = cstu_pkg::FIRE_W;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CFIND = 11'b00000000010,
        S_RDSEM = 11'b00000000100,
        S_EXEC  = 11'b00000001000,
        S_POP   = 11'b00000010000,
        S_POPW  = 11'b00000100000,
        S_TFIND = 11'b00001000000,
        S_TRD   = 11'b00010000000,
        S_TCHK  = 11'b00100000000,
        S_FIRE  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } t_state;

    t_state             r_state;
    cstu_pkg::t_op      r_op;
    logic [SW-1:0]      r_slot;
    logic [TB-1:0]      r_task;
    logic [CW-1:0]      r_init;
    logic [31:0]        r_delay;
    logic [NUM_SEMS-1:0]   r_slot_valid;
    logic [NUM_TIMERS-1:0] r_tvalid;
    logic [SW-1:0]      r_tsem [NUM_TIMERS];
    logic [EW-1:0]      r_now;
    logic [TW-1:0]      r_tidx;
    logic [TW-1:0]      r_best;
    logic [EW-1:0]      r_best_exp;
    logic               r_have_best;
    logic [FW-1:0]      r_fired;
    cstu_pkg::t_result  r_pend;
    logic               r_have_pend;
    cstu_pkg::t_result  r_res;
    logic               r_cont;
    logic [DIW-1:0]     r_sidx;
    logic               r_o_valid;
    cstu_pkg::t_result  r_o;

    logic [CW-1:0]      sem_cnt;
    logic [DW-1:0]      sem_dep;
    logic               sem_we;
    logic [CW-1:0]      sem_wcnt;
    logic [DW-1:0]      sem_wdep;
    logic               stk_we;
    logic [TB-1:0]      stk_rd;
    logic               tmr_we;
    logic [EW-1:0]      tmr_rd;
    logic               exec_pop;
    logic               fin_go;
    cstu_pkg::t_result  fin_res;
    cstu_pkg::t_result  pend_last;
    logic [NUM_TIMERS-1:0] tsem_hit;
    logic               cand;
    logic               best_hit;
    logic               accept;
    logic               in_present;
    logic [SW-1:0]      in_slot;
    logic [SW-1:0]      fire_slot;

    cstu_sem_store #(
        .NUM_SEMS(NUM_SEMS), .SW(SW), .DW(DW), .DIW(DIW), .TB(TB)
    ) u_sem (
        .i_clk         (i_clk),
        .i_rd_slot     (r_slot),
        .o_rd_count    (sem_cnt),
        .o_rd_depth    (sem_dep),
        .i_wr_en       (sem_we),
        .i_wr_slot     (r_slot),
        .i_wr_count    (sem_wcnt),
        .i_wr_depth    (sem_wdep),
        .i_stk_rd_addr ({r_slot, r_sidx}),
        .o_stk_rd_data (stk_rd),
        .i_stk_wr_en   (stk_we),
        .i_stk_wr_addr ({r_slot, sem_dep[DIW-1:0]}),
        .i_stk_wr_data (r_task)
    );

    cstu_tmr_store #(
        .NUM_TIMERS(NUM_TIMERS), .TW(TW)
    ) u_tmr (
        .i_clk       (i_clk),
        .i_rd_addr   (r_tidx),
        .o_rd_expiry (tmr_rd),
        .i_wr_en     (tmr_we),
        .i_wr_addr   (r_tidx),
        .i_wr_expiry (r_now + EW'(r_delay))
    );

    assign o_stall      = (r_state != S_IDLE);
    assign accept       = i_valid && (r_state == S_IDLE);
    assign in_slot      = SW'(i_sem_id);
    assign in_present   = (XW'(i_sem_id) < XW'(NUM_SEMS)) && r_slot_valid[in_slot];
    assign fire_slot    = r_tsem[r_best];
    assign cand         = r_tvalid[r_tidx] && (tmr_rd <= r_now)
                          && (!r_have_best || (tmr_rd < r_best_exp));
    assign best_hit     = r_have_best || cand;

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            tsem_hit[i] = (r_tsem[i] == r_slot);
        end
    end

    always_comb begin
        pend_last      = r_pend;
        pend_last.last = 1'b1;
    end

    always_comb begin
        sem_we   = 1'b0;
        sem_wcnt = sem_cnt;
        sem_wdep = sem_dep;
        stk_we   = 1'b0;
        tmr_we   = 1'b0;
        exec_pop = 1'b0;
        fin_go   = 1'b0;
        fin_res  = '0;
        fin_res.result_id = (r_op == cstu_pkg::OP_TICK) ? 4'(r_slot) : 4'd0;
        fin_res.last = (r_op != cstu_pkg::OP_TICK)
                       || (r_fired == FW'(cstu_pkg::MAX_FIRE - 1));
        unique case (r_state)
            S_CFIND: begin
                if (!r_slot_valid[r_slot]) begin
                    sem_we   = 1'b1;
                    sem_wcnt = r_init;
                    sem_wdep = '0;
                end
            end
            S_TFIND: begin
                tmr_we = !r_tvalid[r_tidx];
            end
            S_EXEC: begin
                unique case (r_op)
                    cstu_pkg::OP_DELETE: begin
                        fin_go = 1'b1;
                        fin_res.status = (sem_dep != '0) ? cstu_pkg::ST_BUSY : cstu_pkg::ST_OK;
                    end
                    cstu_pkg::OP_WAIT: begin
                        fin_go = 1'b1;
                        if (sem_cnt != '0) begin
                            sem_we   = 1'b1;
                            sem_wcnt = sem_cnt - CW'(1);
                            fin_res.status = cstu_pkg::ST_OK;
                        end else if (sem_dep >= DW'(WAIT_DEPTH)) begin
                            fin_res.status = cstu_pkg::ST_BUSY;
                        end else begin
                            stk_we   = 1'b1;
                            sem_we   = 1'b1;
                            sem_wdep = sem_dep + DW'(1);
                            fin_res.status = cstu_pkg::ST_BLOCKED;
                        end
                    end
                    cstu_pkg::OP_SIGNAL, cstu_pkg::OP_TICK: begin
                        if (sem_cnt == '1 && sem_dep == '0) begin
                            fin_go = 1'b1;
                            fin_res.status = cstu_pkg::ST_SATURATED;
                        end else if (sem_dep != '0) begin
                            sem_we   = 1'b1;
                            sem_wdep = sem_dep - DW'(1);
                            exec_pop = 1'b1;
                        end else begin
                            sem_we   = 1'b1;
                            sem_wcnt = sem_cnt + CW'(1);
                            fin_go   = 1'b1;
                            fin_res.status = cstu_pkg::ST_OK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POPW: begin
                fin_go             = 1'b1;
                fin_res.status     = cstu_pkg::ST_OK;
                fin_res.woke       = 1'b1;
                fin_res.woken_task = 8'(stk_rd);
            end
            S_FIRE: begin
                if (!r_slot_valid[fire_slot]) begin
                    fin_go            = 1'b1;
                    fin_res.status    = cstu_pkg::ST_NOT_FOUND;
                    fin_res.result_id = 4'(fire_slot);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot_valid <= '0;
            r_tvalid     <= '0;
            r_now        <= '0;
            r_o_valid    <= 1'b0;
            r_have_pend  <= 1'b0;
            r_have_best  <= 1'b0;
            r_fired      <= '0;
            r_cont       <= 1'b0;
        end else begin
            if (r_o_valid && !i_stall && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= cstu_pkg::t_op'(i_op);
                        r_slot  <= (i_op == cstu_pkg::OP_CREATE) ? '0 : in_slot;
                        r_task  <= TB'(i_task_id);
                        r_init  <= i_init_count;
                        r_delay <= i_delay_us;
                        r_res   <= {cstu_pkg::ST_NOT_FOUND, 4'd0, 1'b0, 8'd0, 1'b1};
                        r_cont  <= 1'b0;
                        unique case (i_op)
                            cstu_pkg::OP_CREATE: begin
                                r_state <= S_CFIND;
                            end
                            cstu_pkg::OP_DELETE, cstu_pkg::OP_WAIT,
                            cstu_pkg::OP_SIGNAL: begin
                                r_state <= in_present ? S_RDSEM : S_EMIT;
                            end
                            cstu_pkg::OP_TIMED: begin
                                r_tidx  <= '0;
                                r_state <= in_present ? S_TFIND : S_EMIT;
                            end
                            cstu_pkg::OP_TICK: begin
                                r_now       <= r_now + EW'(1);
                                r_tidx      <= '0;
                                r_have_best <= 1'b0;
                                r_fired     <= '0;
                                r_have_pend <= 1'b0;
                                r_state     <= S_TRD;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_CFIND: begin
                    if (!r_slot_valid[r_slot]) begin
                        r_slot_valid[r_slot] <= 1'b1;
                        r_res   <= {cstu_pkg::ST_OK, 4'(r_slot), 1'b0, 8'd0, 1'b1};
                        r_state <= S_EMIT;
                    end else if (r_slot == SW'(NUM_SEMS - 1)) begin
                        r_res.status <= cstu_pkg::ST_FULL;
                        r_state      <= S_EMIT;
                    end else begin
                        r_slot <= r_slot + SW'(1);
                    end
                end
                S_RDSEM: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (r_op == cstu_pkg::OP_DELETE && sem_dep == '0) begin
                        r_slot_valid[r_slot] <= 1'b0;
                        r_tvalid             <= r_tvalid & ~tsem_hit;
                    end
                    if (exec_pop) begin
                        r_sidx  <= DIW'(sem_dep - DW'(1));
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_state <= S_POPW;
                end
                S_POPW: begin
                end
                S_TFIND: begin
                    if (!r_tvalid[r_tidx]) begin
                        r_tvalid[r_tidx] <= 1'b1;
                        r_tsem[r_tidx]   <= r_slot;
                        r_res.status     <= cstu_pkg::ST_OK;
                        r_state          <= S_EMIT;
                    end else if (r_tidx == TW'(NUM_TIMERS - 1)) begin
                        r_res.status <= cstu_pkg::ST_TMR_FULL;
                        r_state      <= S_EMIT;
                    end else begin
                        r_tidx <= r_tidx + TW'(1);
                    end
                end
                S_TRD: begin
                    r_state <= S_TCHK;
                end
                S_TCHK: begin
                    if (cand) begin
                        r_best      <= r_tidx;
                        r_best_exp  <= tmr_rd;
                        r_have_best <= 1'b1;
                    end
                    if (r_tidx != TW'(NUM_TIMERS - 1)) begin
                        r_tidx  <= r_tidx + TW'(1);
                        r_state <= S_TRD;
                    end else if (best_hit) begin
                        if (r_have_pend) begin
                            r_res       <= r_pend;
                            r_cont      <= 1'b1;
                            r_have_pend <= 1'b0;
                            r_state     <= S_EMIT;
                        end else begin
                            r_state <= S_FIRE;
                        end
                    end else if (r_have_pend) begin
                        r_res       <= pend_last;
                        r_cont      <= 1'b0;
                        r_have_pend <= 1'b0;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_FIRE: begin
                    r_tvalid[r_best] <= 1'b0;
                    r_slot           <= fire_slot;
                    if (r_slot_valid[fire_slot]) begin
                        r_state <= S_RDSEM;
                    end
                end
                S_EMIT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o       <= r_res;
                        r_o_valid <= 1'b1;
                        r_state   <= r_cont ? S_FIRE : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (fin_go) begin
                if (r_op == cstu_pkg::OP_TICK) begin
                    r_fired <= r_fired + FW'(1);
                end
                if (fin_res.last) begin
                    r_res       <= fin_res;
                    r_cont      <= 1'b0;
                    r_have_pend <= 1'b0;
                    r_state     <= S_EMIT;
                end else begin
                    r_pend      <= fin_res;
                    r_have_pend <= 1'b1;
                    r_tidx      <= '0;
                    r_have_best <= 1'b0;
                    r_state     <= S_TRD;
                end
            end
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o.status;
    assign o_result_id  = r_o.result_id;
    assign o_woke       = r_o.woke;
    assign o_woken_task = r_o.woken_task;
    assign o_last       = r_o.last;

    `CSTU_ASSERT_NXT(a_busy_after_partial, o_valid && !i_stall && !o_last, o_stall || o_valid)
    `CSTU_ASSERT_IMP(a_fire_bound, 1'b1, r_fired <= FW'(cstu_pkg::MAX_FIRE))
    `CSTU_ASSERT_IMP(a_pend_tick_only, r_have_pend && r_state != S_IDLE,
        r_op == cstu_pkg::OP_TICK)
    `CSTU_ASSERT_IMP(a_depth_bound, r_state == S_EXEC, sem_dep <= DW'(WAIT_DEPTH))
endmodule
`default_nettype wire
